// File: hw/rtl/pfde_pkg.sv
// shared types and constants for the page framebuffer draw engine
// no dependencies
package pfde_pkg;

  typedef enum logic [2:0] {
    REQ_PUT_PIXEL = 3'd0,
    REQ_GET_PIXEL = 3'd1,
    REQ_PUT_BYTE  = 3'd2,
    REQ_HLINE     = 3'd3,
    REQ_VLINE     = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SET    = 2'd1,
    MODE_INVERT = 2'd2
  } mode_t;

  localparam logic [2:0] BIT_IDX_MASK = 3'h7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WAIT,
    ST_WRITE,
    ST_DONE
  } state_t;

  function automatic logic [7:0] apply_paint(input logic [7:0] old_b,
                                             input logic [7:0] mask,
                                             input logic [1:0] mode);
    logic [7:0] res;
    begin
      res = old_b;
      case (mode)
        MODE_CLEAR:  res = old_b & ~mask;
        MODE_SET:    res = old_b | mask;
        MODE_INVERT: res = old_b ^ mask;
        default:     res = old_b;
      endcase
      return res;
    end
  endfunction

endpackage

// File: hw/rtl/pfde_front.sv
// front end: classifies commands, checks ranges, turns them into spans of byte ops
// depends on pfde_pkg
module pfde_front
  import pfde_pkg::*;
#(
  parameter int XW = 7,
  parameter int YW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_req_type,
  input  logic [6:0]    in_pos_x,
  input  logic [5:0]    in_pos_y,
  input  logic [6:0]    in_end_x,
  input  logic [5:0]    in_end_y,
  input  logic [7:0]    in_data_byte,
  input  logic [1:0]    in_paint_mode,
  input  logic [XW:0]   eff_w,
  input  logic [YW:0]   eff_h,
  // queue entry
  output logic          q_valid,
  input  logic          q_ready,
  output logic [2:0]    q_req,
  output logic          q_ok,
  output logic [XW-1:0] q_x0,
  output logic [XW-1:0] q_x1,
  output logic [YW-1:0] q_y0,
  output logic [YW-1:0] q_y1,
  output logic [7:0]    q_byte,
  output logic [1:0]    q_mode
);

  logic          full_r;
  logic [2:0]    req_r;
  logic          ok_r;
  logic [XW-1:0] x0_r, x1_r;
  logic [YW-1:0] y0_r, y1_r;
  logic [7:0]    byte_r;
  logic [1:0]    mode_r;

  logic [XW:0] xa, xb;
  logic [YW:0] ya, yb;
  logic        xok, exok, yok, eyok, mok, ok;
  logic [YW:0] hi_y;

  assign xa   = (XW+1)'(in_pos_x);
  assign xb   = (XW+1)'(in_end_x);
  assign ya   = (YW+1)'(in_pos_y);
  assign yb   = (YW+1)'(in_end_y);
  assign xok  = xa < eff_w;
  assign exok = xb < eff_w;
  assign yok  = ya < eff_h;
  assign eyok = yb < eff_h;
  assign mok  = in_paint_mode != 2'd3;

  // range check per command
  always_comb begin
    case (in_req_type)
      REQ_PUT_PIXEL, REQ_PUT_BYTE: ok = xok && yok && mok;
      REQ_GET_PIXEL:               ok = xok && yok;
      REQ_HLINE:                   ok = xok && exok && yok && mok;
      REQ_VLINE:                   ok = xok && (yok || eyok);
      default:                     ok = 1'b0;
    endcase
  end

  assign hi_y = (ya > yb) ? ya : yb;

  assign in_stall = full_r && !q_ready;

  // one-entry queue register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full_r <= 1'b1;
    end else if (q_ready) begin
      full_r <= 1'b0;
    end
  end

  // only the horizontal line orders its end columns
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r  <= in_req_type;
      ok_r   <= ok;
      x0_r   <= (in_req_type == REQ_HLINE && in_end_x < in_pos_x) ?
                XW'(in_end_x) : XW'(in_pos_x);
      x1_r   <= (in_req_type == REQ_HLINE && in_pos_x < in_end_x) ?
                XW'(in_end_x) : XW'(in_pos_x);
      y0_r   <= (in_req_type == REQ_VLINE && in_end_y < in_pos_y) ?
                YW'(in_end_y) : YW'(in_pos_y);
      y1_r   <= (in_req_type == REQ_VLINE) ?
                ((hi_y >= eff_h) ? YW'(eff_h - 1'b1) : YW'(hi_y)) : YW'(in_pos_y);
      byte_r <= in_data_byte;
      mode_r <= (in_req_type == REQ_VLINE) ? MODE_SET : in_paint_mode;
    end
  end

  assign q_valid = full_r;
  assign q_req   = req_r;
  assign q_ok    = ok_r;
  assign q_x0    = x0_r;
  assign q_x1    = x1_r;
  assign q_y0    = y0_r;
  assign q_y1    = y1_r;
  assign q_byte  = byte_r;
  assign q_mode  = mode_r;

endmodule

// File: hw/rtl/pfde_back.sv
// back end: clears the store after reset, runs read-modify-write byte ops
// depends on pfde_pkg
module pfde_back
  import pfde_pkg::*;
#(
  parameter int XW = 7,
  parameter int YW = 6,
  parameter int PW = 3,
  parameter int AW = 10,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [XW:0]   eff_w,
  input  logic [PW:0]   eff_pages,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [2:0]    q_req,
  input  logic          q_ok,
  input  logic [XW-1:0] q_x0,
  input  logic [XW-1:0] q_x1,
  input  logic [YW-1:0] q_y0,
  input  logic [YW-1:0] q_y1,
  input  logic [7:0]    q_byte,
  input  logic [1:0]    q_mode,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_pixel_value,
  output logic          out_in_range
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;

  state_t state_r, state_nxt;
  logic [AW:0]   clr_r;
  logic [2:0]    req_r;
  logic [XW-1:0] col_r, col_end_r;
  logic [YW-1:0] row_r, row_end_r;
  logic [7:0]    byte_r;
  logic [1:0]    mode_r;
  logic          ok_r;
  logic          second_r;
  logic          ov_r, pix_r, rng_r;

  // byte op in progress
  logic [PW-1:0] page;
  logic [2:0]    bit_i;
  logic [15:0]   wide;
  logic [7:0]    mask;
  logic [AW+XW:0] idx_full;
  logic [AW-1:0] idx;
  logic          idx_ok;
  logic          last_op;
  logic          wr_en;
  logic [7:0]    wr_data;

  assign bit_i = row_r[2:0] & BIT_IDX_MASK;
  assign page  = PW'(row_r >> 3) + PW'(second_r);
  assign wide  = {8'd0, byte_r} << bit_i;
  assign idx_full = (AW+XW+1)'(page) * (AW+XW+1)'(eff_w) + (AW+XW+1)'(col_r);
  assign idx   = idx_full[AW-1:0];
  assign idx_ok = idx_full < (AW+XW+1)'(DEPTH);

  always_comb begin
    if (req_r == REQ_PUT_BYTE) begin
      mask = second_r ? wide[15:8] : wide[7:0];
    end else begin
      mask = 8'd1 << bit_i;
    end
  end

  // last byte op of the command
  always_comb begin
    case (req_r)
      REQ_PUT_BYTE: last_op = second_r || bit_i == 3'd0 ||
                              ((PW+1)'(row_r >> 3) + 1'b1 >= eff_pages);
      REQ_HLINE:    last_op = col_r == col_end_r;
      REQ_VLINE:    last_op = row_r == row_end_r;
      default:      last_op = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == (AW+1)'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = q_ok ? ST_READ : ST_DONE;
      ST_READ:  state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = (req_r == REQ_GET_PIXEL) ? ST_DONE : ST_WRITE;
      ST_WRITE: state_nxt = last_op ? ST_DONE : ST_READ;
      ST_DONE:  if (!ov_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_ready = 1'b0;
    wr_en   = 1'b0;
    wr_data = apply_paint(rd_q, mask, mode_r);
    unique case (state_r)
      ST_IDLE:  q_ready = 1'b1;
      ST_WRITE: wr_en = idx_ok;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_DONE && (!ov_r || !out_stall)) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  // command registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) begin
      req_r     <= q_req;
      ok_r      <= q_ok;
      col_r     <= q_x0;
      col_end_r <= q_x1;
      row_r     <= q_y0;
      row_end_r <= q_y1;
      byte_r    <= q_byte;
      mode_r    <= q_mode;
      second_r  <= 1'b0;
    end else if (state_r == ST_WRITE && !last_op) begin
      case (req_r)
        REQ_PUT_BYTE: second_r <= 1'b1;
        REQ_HLINE:    col_r <= col_r + 1'b1;
        REQ_VLINE:    row_r <= row_r + 1'b1;
        default:      ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!ov_r || !out_stall)) begin
      rng_r <= ok_r;
      pix_r <= ok_r && req_r == REQ_GET_PIXEL && idx_ok && rd_q[bit_i];
    end
  end

  // frame memory
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_r[AW-1:0]] <= 8'd0;
    end else if (wr_en) begin
      mem[idx] <= wr_data;
    end
    if (state_r == ST_READ) rd_q <= mem[idx];
  end

  assign out_valid       = ov_r;
  assign out_pixel_value = pix_r;
  assign out_in_range    = rng_r;

endmodule

// File: hw/rtl/page_framebuffer_draw_engine.sv
// top level of the page framebuffer draw engine
// depends on pfde_pkg, pfde_front, pfde_back
//
// Monochrome page framebuffer. Each memory byte is eight vertical pixels
// of one column; pages are eight rows. Commands come in on the in_ channel
// (valid/stall) and each gives one word on the out_ channel: the pixel read
// by get pixel and an in-range flag. cfg_ writes set screen width (index 0)
// and height (index 1) and are always ready.
// The front register feeds a byte sequencer. Each byte op is a read,
// a wait for registered read data and a write. Rejected commands skip
// the byte ops; a pixel takes one byte op, a put byte up to two, and a
// line one per column or row. The single frame memory port pair sets
// the rate of byte ops.
// After reset the memory is cleared one byte a cycle, all MAX_WIDTH *
// (MAX_HEIGHT / 8) bytes, before the first command runs; commands queue in
// the front register meanwhile. When out_stall is high the result holds and
// the sequencer waits; the front register still takes one more command.
module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [6:0] in_pos_x,
  input  logic [5:0] in_pos_y,
  input  logic [6:0] in_end_x,
  input  logic [5:0] in_end_y,
  input  logic [7:0] in_data_byte,
  input  logic [1:0] in_paint_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pixel_value,
  output logic       out_in_range,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int XW = 8;
  localparam int YW = 8;
  localparam int PW = 6;
  localparam int DEPTH = MAX_WIDTH * (MAX_HEIGHT / 8);
  localparam int AW = $clog2(DEPTH);
  localparam int MAXH8 = (MAX_HEIGHT / 8) * 8;

  logic [7:0] width_r;
  logic [6:0] height_r;
  logic [XW:0] eff_w;
  logic [YW:0] eff_h;
  logic [PW:0] eff_pages;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) width_r <= cfg_data;
      else                   height_r <= cfg_data[6:0];
    end
  end

  // effective screen size
  always_comb begin
    eff_w = (XW+1)'(width_r);
    if (eff_w == '0) eff_w = (XW+1)'(1);
    if (eff_w > (XW+1)'(MAX_WIDTH)) eff_w = (XW+1)'(MAX_WIDTH);
    eff_h = (YW+1)'({height_r[6:3], 3'b000});
    if (eff_h > (YW+1)'(MAXH8)) eff_h = (YW+1)'(MAXH8);
    if (eff_h < (YW+1)'(8)) eff_h = (YW+1)'(8);
  end
  assign eff_pages = (PW+1)'(eff_h >> 3);

  logic          q_valid, q_ready, q_ok;
  logic [2:0]    q_req;
  logic [XW-1:0] q_x0, q_x1;
  logic [YW-1:0] q_y0, q_y1;
  logic [7:0]    q_byte;
  logic [1:0]    q_mode;

  pfde_front #(.XW(XW), .YW(YW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_pos_x, .in_pos_y,
    .in_end_x, .in_end_y, .in_data_byte, .in_paint_mode,
    .eff_w, .eff_h,
    .q_valid, .q_ready, .q_req, .q_ok, .q_x0, .q_x1, .q_y0, .q_y1,
    .q_byte, .q_mode
  );

  pfde_back #(.XW(XW), .YW(YW), .PW(PW), .AW(AW), .DEPTH(DEPTH)) u_back (
    .clk, .rst_n, .eff_w, .eff_pages,
    .q_valid, .q_ready, .q_req, .q_ok, .q_x0, .q_x1, .q_y0, .q_y1,
    .q_byte, .q_mode,
    .out_valid, .out_stall, .out_pixel_value, .out_in_range
  );

endmodule

// File: verif/tb.sv
// testbench for the page framebuffer draw engine: directed and random draw commands
// checked against a local pixel store model; depends on pfde_pkg and the rtl top
`timescale 1ns / 1ps

module tb;
  import pfde_pkg::*;

  typedef struct packed {
    logic [2:0] req;
    logic [6:0] x;
    logic [5:0] y;
    logic [6:0] ex;
    logic [5:0] ey;
    logic [7:0] data;
    logic [1:0] mode;
  } draw_cmd_t;

  typedef struct packed {
    logic pix;
    logic ok;
  } draw_resp_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 600;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_req_type;
  logic [6:0] in_pos_x;
  logic [5:0] in_pos_y;
  logic [6:0] in_end_x;
  logic [5:0] in_end_y;
  logic [7:0] in_data_byte;
  logic [1:0] in_paint_mode;
  logic       out_valid;
  logic       out_stall;
  logic       out_pixel_value;
  logic       out_in_range;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [7:0] cfg_data;

  draw_cmd_t  cmd_q[$];
  draw_resp_t resp_q[$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         fail_count;
  int         quiet_cycles;

  // local copy of the frame and the size registers
  logic [7:0] pixel_bytes[1024];
  logic [7:0] width_reg;
  logic [6:0] height_reg;

  page_framebuffer_draw_engine uut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int cur_width();
    if (width_reg == 8'd0) return 1;
    if (width_reg > 8'd128) return 128;
    return int'(width_reg);
  endfunction

  function automatic int cur_height();
    int h;
    h = int'(height_reg) & ~7;
    if (h > 64) h = 64;
    if (h < 8) h = 8;
    return h;
  endfunction

  function automatic void paint_byte(int page, int col, logic [7:0] mask, logic [1:0] mode);
    int idx;
    idx = page * cur_width() + col;
    if (idx >= 1024) return;
    case (mode)
      MODE_CLEAR:  pixel_bytes[idx] = pixel_bytes[idx] & ~mask;
      MODE_SET:    pixel_bytes[idx] = pixel_bytes[idx] | mask;
      MODE_INVERT: pixel_bytes[idx] = pixel_bytes[idx] ^ mask;
      default: ;
    endcase
  endfunction

  // apply one command to the local frame and give the expected word
  function automatic draw_resp_t draw_predict(draw_cmd_t c);
    draw_resp_t r;
    int w, h, lo, hi, off, page, idx;
    logic [15:0] wide;
    w = cur_width();
    h = cur_height();
    r = '0;
    if (c.req == REQ_PUT_PIXEL) begin
      if (c.x < w && c.y < h && c.mode <= MODE_INVERT) begin
        paint_byte(c.y >> 3, c.x, 8'(1 << c.y[2:0]), c.mode);
        r.ok = 1'b1;
      end
    end else if (c.req == REQ_GET_PIXEL) begin
      if (c.x < w && c.y < h) begin
        idx = (c.y >> 3) * w + c.x;
        r.pix = (idx < 1024) ? pixel_bytes[idx][c.y[2:0]] : 1'b0;
        r.ok = 1'b1;
      end
    end else if (c.req == REQ_PUT_BYTE) begin
      if (c.x < w && c.y < h && c.mode <= MODE_INVERT) begin
        off = c.y[2:0];
        page = c.y >> 3;
        wide = {8'd0, c.data} << off;
        paint_byte(page, c.x, wide[7:0], c.mode);
        if (off != 0 && page + 1 < (h >> 3)) paint_byte(page + 1, c.x, wide[15:8], c.mode);
        r.ok = 1'b1;
      end
    end else if (c.req == REQ_HLINE) begin
      if (c.x < w && c.ex < w && c.y < h && c.mode <= MODE_INVERT) begin
        lo = (c.x < c.ex) ? c.x : c.ex;
        hi = (c.x < c.ex) ? c.ex : c.x;
        for (int col = lo; col <= hi; col++)
          paint_byte(c.y >> 3, col, 8'(1 << c.y[2:0]), c.mode);
        r.ok = 1'b1;
      end
    end else if (c.req == REQ_VLINE) begin
      if (c.x < w && !(c.y >= h && c.ey >= h)) begin
        lo = (c.y < c.ey) ? c.y : c.ey;
        hi = (c.y < c.ey) ? c.ey : c.y;
        if (hi >= h) hi = h - 1;
        for (int row = lo; row <= hi; row++)
          paint_byte(row >> 3, c.x, 8'(1 << (row & 7)), MODE_SET);
        r.ok = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  task automatic queue_cmd(logic [2:0] req, int x, int y, int ex, int ey, int data, int mode);
    draw_cmd_t c;
    c.req = req;
    c.x = 7'(x);
    c.y = 6'(y);
    c.ex = 7'(ex);
    c.ey = 6'(ey);
    c.data = 8'(data);
    c.mode = 2'(mode);
    cmd_q.push_back(c);
  endtask

  function automatic int pick_col();
    if ($urandom_range(99) < 80) return $urandom_range(cur_width() - 1);
    return $urandom_range(127);
  endfunction

  function automatic int pick_row();
    if ($urandom_range(99) < 80) return $urandom_range(cur_height() - 1);
    return $urandom_range(63);
  endfunction

  // random command mix, mostly in range with legal paint modes
  task automatic queue_random(int n);
    int k, mode, x;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      mode = ($urandom_range(99) < 8) ? 3 : $urandom_range(2);
      x = pick_col();
      if (k < 20) queue_cmd(REQ_PUT_PIXEL, x, pick_row(), $urandom_range(127),
                            $urandom_range(63), $urandom_range(255), mode);
      else if (k < 50) queue_cmd(REQ_GET_PIXEL, x, pick_row(), $urandom_range(127),
                                 $urandom_range(63), $urandom_range(255), $urandom_range(3));
      else if (k < 65) queue_cmd(REQ_PUT_BYTE, x, pick_row(), $urandom_range(127),
                                 $urandom_range(63), $urandom_range(255), mode);
      else if (k < 78) queue_cmd(REQ_HLINE, x, pick_row(),
                                 ($urandom_range(3) == 0) ? pick_col()
                                   : (x + $urandom_range(8)) % cur_width(),
                                 $urandom_range(63), $urandom_range(255), mode);
      else if (k < 93) queue_cmd(REQ_VLINE, x, pick_row(), $urandom_range(127), pick_row(),
                                 $urandom_range(255), $urandom_range(3));
      else queue_cmd(3'($urandom_range(5, 7)), $urandom_range(127), $urandom_range(63),
                     $urandom_range(127), $urandom_range(63), $urandom_range(255),
                     $urandom_range(3));
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() > 0 || in_valid || resp_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx) height_reg = val[6:0];
    else width_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] w, logic [7:0] h, int idle, int stall, int n);
    wait_drained();
    write_reg(1'b0, w);
    write_reg(1'b1, h);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    queue_random(n);
  endtask

  // stimulus sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    in_data_byte = '0;
    in_paint_mode = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    width_reg = 8'd128;
    height_reg = 7'd64;
    foreach (pixel_bytes[i]) pixel_bytes[i] = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, straddles, reversed ends, bad modes, unknown requests
    queue_cmd(REQ_GET_PIXEL, 127, 63, 0, 0, 0, MODE_CLEAR);
    queue_cmd(REQ_PUT_PIXEL, 0, 0, 0, 0, 0, MODE_SET);
    queue_cmd(REQ_PUT_PIXEL, 127, 63, 0, 0, 0, MODE_INVERT);
    queue_cmd(REQ_GET_PIXEL, 0, 0, 0, 0, 0, MODE_SET);
    queue_cmd(REQ_GET_PIXEL, 127, 63, 0, 0, 0, MODE_SET);
    queue_cmd(REQ_PUT_BYTE, 5, 0, 0, 0, 8'hFF, MODE_SET);
    queue_cmd(REQ_PUT_BYTE, 6, 3, 0, 0, 8'hA5, MODE_INVERT);
    queue_cmd(REQ_GET_PIXEL, 6, 10, 0, 0, 0, MODE_SET);
    queue_cmd(REQ_PUT_BYTE, 7, 61, 0, 0, 8'hFF, MODE_SET);
    queue_cmd(REQ_PUT_BYTE, 5, 2, 0, 0, 8'h0F, MODE_CLEAR);
    queue_cmd(REQ_PUT_BYTE, 5, 2, 0, 0, 8'h0F, 3);
    queue_cmd(REQ_HLINE, 127, 9, 0, 0, 0, MODE_SET);
    queue_cmd(REQ_HLINE, 10, 9, 20, 0, 0, MODE_INVERT);
    queue_cmd(REQ_GET_PIXEL, 15, 9, 0, 0, 0, MODE_SET);
    queue_cmd(REQ_HLINE, 3, 4, 3, 0, 0, MODE_CLEAR);
    queue_cmd(REQ_HLINE, 3, 4, 8, 0, 0, 3);
    queue_cmd(REQ_VLINE, 50, 63, 0, 0, 0, 3);
    queue_cmd(REQ_VLINE, 51, 20, 20, 20, 0, MODE_CLEAR);
    queue_cmd(REQ_GET_PIXEL, 50, 31, 0, 0, 0, MODE_SET);
    queue_cmd(REQ_PUT_PIXEL, 1, 1, 0, 0, 0, 3);
    queue_cmd(3'd5, 1, 1, 1, 1, 8'hFF, MODE_SET);
    queue_cmd(3'd7, 127, 63, 127, 63, 8'hFF, 3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(250);

    run_phase(8'd1, 8'd8, 47, 0, 250);
    run_phase(8'd255, 8'd127, 0, 47, 250);
    run_phase(8'd0, 8'd0, 37, 37, 250);
    run_phase(8'd40, 8'd23, 47, 0, 250);
    run_phase(8'd128, 8'd64, 0, 47, 250);
    run_phase(8'd100, 8'd47, 37, 37, 250);

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // command driver: predicts at acceptance, loads the next word at the falling edge
  logic in_took;
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      resp_q.push_back(draw_predict({in_req_type, in_pos_x, in_pos_y, in_end_x, in_end_y,
                                     in_data_byte, in_paint_mode}));
    end
  end

  always @(negedge clk) begin
    draw_cmd_t c;
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = cmd_q.pop_front();
          in_req_type <= c.req;
          in_pos_x <= c.x;
          in_pos_y <= c.y;
          in_end_x <= c.ex;
          in_end_y <= c.ey;
          in_data_byte <= c.data;
          in_paint_mode <= c.mode;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    draw_resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (resp_q.size() == 0) begin
        report_mismatch("unexpected word, in_range", out_in_range, 0);
      end else begin
        want = resp_q.pop_front();
        if (out_pixel_value !== want.pix) report_mismatch("pixel_value", out_pixel_value, want.pix);
        if (out_in_range !== want.ok) report_mismatch("in_range", out_in_range, want.ok);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout waiting for a handshake");
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: filelist.f
hw/rtl/pfde_pkg.sv
hw/rtl/pfde_front.sv
hw/rtl/pfde_back.sv
hw/rtl/page_framebuffer_draw_engine.sv
verif/tb.sv
